// ===== design/gjsd_pkg.sv =====
// Shared types, constants and helpers for the greedy job shop dispatcher.
package gjsd_pkg;

  localparam int MAX_JOBS_DEF     = 16;
  localparam int MAX_MACHINES_DEF = 16;
  localparam int OPS_PER_JOB_DEF  = 16;

  localparam int IDX_W     = 4;
  localparam int DUR_W     = 16;
  localparam int TIME_W    = 24;
  localparam int SUM_W     = 28;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 7;   // holds any clamped count up to 64

  localparam logic [CFG_W-1:0] JOBS_RESET     = CFG_W'(16);
  localparam logic [CFG_W-1:0] MACHINES_RESET = CFG_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_JOBS_IN_USE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MACHINES_IN_USE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [IDX_W-1:0] job_index;
    logic [IDX_W-1:0] mach_id;
    logic [DUR_W-1:0] op_ticks;
    logic             end_of_load;
  } in_pkt_t;

  typedef struct packed {
    logic [SUM_W-1:0] total_completion_time;
    logic             load_error;
  } out_pkt_t;

  typedef struct packed {
    logic [IDX_W-1:0] machine;
    logic [DUR_W-1:0] duration;
  } op_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_START,
    ST_END,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;        // take the input request into its job queue
    logic scan_init;   // restart the job scan
    logic rd;          // read head operation of the current job
    logic start;       // form start time
    logic eval;        // form finish time, keep the best, step the scan
    logic commit;      // dispatch the best operation
    logic emit_clear;  // latch result, clear the load
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
  } dp_sts_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                   input logic [CNT_W-1:0] max_v);
    logic [CNT_W-1:0] w;
    w = CNT_W'(v);
    if (w == '0) begin
      return CNT_W'(1);
    end
    if (w > max_v) begin
      return max_v;
    end
    return w;
  endfunction

endpackage

// ===== design/greedy_job_shop_dispatcher_core.sv =====
// Top level of the greedy job shop dispatcher.
// Each accepted operation request is appended to its job's queue; the
// request flagged end_of_load then starts scheduling and the input stalls
// until the result is in the output register. Scheduling runs dispatch
// rounds that scan the first N jobs, N being the clamped jobs_in_use: every
// job gets a registered read of its head operation from the operation
// store, then its start time from the machine and job times, then the
// saturating finish time and compare against the running best, and a
// commit step then dispatches the winner. There is one round per dispatched
// operation plus a final empty round, after which the result is loaded into
// the output register once that register is free.
// A waiting result does not block the next load; only a second result waits
// for the first to be taken. There is no clearing pass after reset.
module greedy_job_shop_dispatcher_core #(
  parameter int MAX_JOBS     = gjsd_pkg::MAX_JOBS_DEF,
  parameter int MAX_MACHINES = gjsd_pkg::MAX_MACHINES_DEF,
  parameter int OPS_PER_JOB  = gjsd_pkg::OPS_PER_JOB_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gjsd_pkg::in_pkt_t              in_pkt,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gjsd_pkg::out_pkt_t             out_pkt,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gjsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gjsd_pkg::CFG_W-1:0]     cfg_data
);
  import gjsd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  gjsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_pkt.end_of_load),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  gjsd_datapath #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES),
    .OPS_PER_JOB  (OPS_PER_JOB)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pkt    (in_pkt),
    .out_pkt   (out_pkt),
    .cmd       (cmd),
    .sts       (sts)
  );

  // the closing request of a load starts a schedule, so input stalls next
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_pkt.end_of_load) |=> in_stall)
    else $error("input not stalled after end of load");

  // a dispatch only happens when the scan found a candidate
  a_commit_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.found)
    else $error("commit without a candidate");

  // queue writes happen only on an accepted request
  a_load_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && !in_stall))
    else $error("load command without accepted request");

  // a new result only enters a free or draining output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_clear |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending result");

endmodule

// ===== design/gjsd_ctrl.sv =====
// Sequencer: load, scan rounds, dispatch and result hand-off.
module gjsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gjsd_pkg::dp_cmd_t cmd,
  input  gjsd_pkg::dp_sts_t sts
);
  import gjsd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_END;
      end
      ST_END: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.scan_last ? ST_COMMIT : ST_ADDR;
      end
      ST_COMMIT: begin
        if (sts.found) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_ADDR;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.emit_clear = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/gjsd_datapath.sv =====
// Operation store, job/machine timing registers and the dispatch arithmetic.
module gjsd_datapath #(
  parameter int MAX_JOBS     = gjsd_pkg::MAX_JOBS_DEF,
  parameter int MAX_MACHINES = gjsd_pkg::MAX_MACHINES_DEF,
  parameter int OPS_PER_JOB  = gjsd_pkg::OPS_PER_JOB_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [gjsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gjsd_pkg::CFG_W-1:0]     cfg_data,
  input  gjsd_pkg::in_pkt_t              in_pkt,
  output gjsd_pkg::out_pkt_t             out_pkt,
  input  gjsd_pkg::dp_cmd_t              cmd,
  output gjsd_pkg::dp_sts_t              sts
);
  import gjsd_pkg::*;

  localparam int JW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int MW    = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int QW    = $clog2(OPS_PER_JOB + 1);
  localparam int DEPTH = MAX_JOBS * OPS_PER_JOB;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [CFG_W-1:0] jobs_in_use_r, machines_in_use_r;
  logic [CNT_W-1:0] nj, nm;

  // per-job and per-machine state
  logic [QW-1:0]     qlen_r   [MAX_JOBS];
  logic [QW-1:0]     qhead_r  [MAX_JOBS];
  logic [TIME_W-1:0] jready_r [MAX_JOBS];
  logic [TIME_W-1:0] mfree_r  [MAX_MACHINES];
  logic [SUM_W-1:0]  sum_r;
  logic              err_r;

  // operation store
  op_entry_t mem [DEPTH];
  op_entry_t mem_q_r;

  // scan state
  logic [JW-1:0]     job_r, best_job_r;
  logic              found_r, has_op_r;
  logic [TIME_W-1:0] cur_ready_r, start_r, best_end_r;
  logic [DUR_W-1:0]  dur_r;
  logic [MW-1:0]     best_mach_r;
  out_pkt_t          out_pkt_r;

  logic [JW-1:0]     sel_job;
  logic [QW-1:0]     qlen_sel, qhead_sel, head_inc;
  logic              bad_op, mem_we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [MW-1:0]     mach_idx;
  logic [TIME_W-1:0] mfree_sel, start_val, end_val;
  logic [TIME_W:0]   end_sum;
  logic [SUM_W:0]    sum_add;
  logic              better, scan_last;

  assign nj = clamp_count(jobs_in_use_r, CNT_W'(MAX_JOBS));
  assign nm = clamp_count(machines_in_use_r, CNT_W'(MAX_MACHINES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jobs_in_use_r     <= JOBS_RESET;
      machines_in_use_r <= MACHINES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_JOBS_IN_USE:     jobs_in_use_r     <= cfg_data;
        REG_MACHINES_IN_USE: machines_in_use_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // one job-indexed read per cycle: load, scan or commit
  always_comb begin
    sel_job = job_r;
    if (cmd.load) begin
      sel_job = JW'(in_pkt.job_index);
    end else if (cmd.commit) begin
      sel_job = best_job_r;
    end
  end

  assign qlen_sel  = qlen_r[sel_job];
  assign qhead_sel = qhead_r[sel_job];
  assign head_inc  = QW'(qhead_sel + 1'b1);

  assign bad_op = (CNT_W'(in_pkt.job_index) >= nj) ||
                  (CNT_W'(in_pkt.mach_id) >= nm) ||
                  (qlen_sel >= QW'(OPS_PER_JOB));
  assign mem_we  = cmd.load && !bad_op;
  assign wr_addr = AW'(AW'(sel_job) * AW'(OPS_PER_JOB) + AW'(qlen_sel));
  assign rd_addr = AW'(AW'(sel_job) * AW'(OPS_PER_JOB) + AW'(qhead_sel));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= '{machine: in_pkt.mach_id, duration: in_pkt.op_ticks};
    end
    if (cmd.rd) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign mach_idx  = MW'(mem_q_r.machine);
  assign mfree_sel = mfree_r[mach_idx];
  assign start_val = (mfree_sel > cur_ready_r) ? mfree_sel : cur_ready_r;

  // finish time saturates at the top of the time range
  assign end_sum   = {1'b0, start_r} + (TIME_W + 1)'(dur_r);
  assign end_val   = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
  assign better    = has_op_r && (!found_r || (end_val < best_end_r));
  assign scan_last = (CNT_W'(job_r) == CNT_W'(nj - CNT_W'(1)));
  assign sum_add   = {1'b0, sum_r} + (SUM_W + 1)'(best_end_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit_clear) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        qlen_r[i]   <= '0;
        qhead_r[i]  <= '0;
        jready_r[i] <= '0;
      end
      for (int i = 0; i < MAX_MACHINES; i++) begin
        mfree_r[i] <= '0;
      end
      sum_r <= '0;
      err_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (bad_op) begin
          err_r <= 1'b1;
        end else begin
          qlen_r[sel_job] <= QW'(qlen_sel + 1'b1);
        end
      end
      if (cmd.commit) begin
        mfree_r[best_mach_r] <= best_end_r;
        jready_r[sel_job]    <= best_end_r;
        qhead_r[sel_job]     <= head_inc;
        if (head_inc >= qlen_sel) begin
          sum_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_init || cmd.commit) begin
      job_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.eval) begin
      if (better) begin
        found_r <= 1'b1;
      end
      if (!scan_last) begin
        job_r <= JW'(job_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      has_op_r    <= (qhead_sel < qlen_sel);
      cur_ready_r <= jready_r[sel_job];
    end
    if (cmd.start) begin
      start_r <= start_val;
      dur_r   <= mem_q_r.duration;
    end
    // strict compare keeps the lowest job on ties
    if (cmd.eval && better) begin
      best_end_r  <= end_val;
      best_job_r  <= job_r;
      best_mach_r <= mach_idx;
    end
    if (cmd.emit_clear) begin
      out_pkt_r.total_completion_time <= sum_r;
      out_pkt_r.load_error            <= err_r;
    end
  end

  assign sts.scan_last = scan_last;
  assign sts.found     = found_r;
  assign out_pkt       = out_pkt_r;

endmodule
